FILE: rtl/prsmf_pkg.sv
// ----------------------------------------------------------------------------
// prsmf_pkg
// Shared types, codes and helper functions for the paired ranging scan
// median filter unit.
// ----------------------------------------------------------------------------
package prsmf_pkg;

    localparam int unsigned WINDOW_TAPS  = 3;
    localparam int unsigned SENSOR_COUNT = 4;
    localparam int unsigned PAIR_COUNT   = SENSOR_COUNT / 2;

    localparam int unsigned RAW_W   = 16;
    localparam int unsigned WAIT_W  = 10;
    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [RAW_W-1:0]  BAD_VALUE   = 16'd999;
    localparam logic [RAW_W-1:0]  MAX_VALID   = 16'd65000;
    localparam logic [WAIT_W-1:0] WAIT_RESET  = 10'd30;
    localparam logic [WAIT_W-1:0] ELAPSED_MAX = 10'd1023;

    localparam logic [CFG_IDX_W-1:0] REG_WAIT_PAIR0 = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_WAIT_PAIR1 = 1'b1;

    localparam logic CMD_TICK    = 1'b0;
    localparam logic CMD_READING = 1'b1;

    localparam logic [1:0] ACT_NONE     = 2'd0;
    localparam logic [1:0] ACT_TRIGGER  = 2'd1;
    localparam logic [1:0] ACT_READ     = 2'd2;
    localparam logic [1:0] ACT_FILTERED = 2'd3;

    typedef enum logic [2:0] {
        PH_TRIGGER = 3'b001,
        PH_WAIT    = 3'b010,
        PH_AWAIT   = 3'b100
    } phase_t;

    typedef struct packed {
        logic             command;
        logic [RAW_W-1:0] first_raw;
        logic             first_bus_ok;
        logic [RAW_W-1:0] second_raw;
        logic             second_bus_ok;
    } scan_t;

    typedef struct packed {
        logic [1:0]       action;
        logic             pair_index;
        logic [RAW_W-1:0] filtered_first;
        logic [RAW_W-1:0] filtered_second;
    } result_t;

    typedef struct packed {
        logic       enable;
        logic       pair;
        logic [1:0] action;
    } step_t;

    function automatic logic [RAW_W-1:0] clean_value(input logic [RAW_W-1:0] raw,
                                                     input logic ok);
        logic bad;
        bad = !ok || (raw == '0) || (raw > MAX_VALID);
        return bad ? BAD_VALUE : raw;
    endfunction

    function automatic logic [RAW_W-1:0] median3(input logic [RAW_W-1:0] a,
                                                 input logic [RAW_W-1:0] b,
                                                 input logic [RAW_W-1:0] c);
        logic [RAW_W-1:0] m;
        if ((a <= b && b <= c) || (c <= b && b <= a))
            m = b;
        else if ((b <= a && a <= c) || (c <= a && a <= b))
            m = a;
        else
            m = c;
        return m;
    endfunction

endpackage

FILE: rtl/paired_ranging_scan_median_filter_unit.sv
// ----------------------------------------------------------------------------
// paired_ranging_scan_median_filter_unit
// Two-pair range sensor scan sequencer with median-of-three filtering.
// ----------------------------------------------------------------------------
// Usage:
//   scan channel (scan_valid/scan_stall/scan_data) carries ticks and readings;
//   each request yields exactly one request on the result channel
//   (result_valid/result_stall/result_data) with the action taken.
//   Configuration: cfg_we with cfg_index/cfg_data writes a wait register
//   (index 0: pair 0 wait, index 1: pair 1 wait); write only while idle.
//   Path: a request passes the input register and then the result register
//   (two register stages); a result stall holds it in the input register.
//   Throughput: one request per cycle without result stall, set by one pass
//   through the sequencer and window logic between the two registers.
//   Reset: trigger phase, pair 0, counter and all windows cleared, waits 30.
//   Stall: a held result keeps its data; one more request is held in the
//   input register, after which scan_stall rises until the result is taken.
// ----------------------------------------------------------------------------
module paired_ranging_scan_median_filter_unit
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [prsmf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [prsmf_pkg::WAIT_W-1:0]      cfg_data,
    input  logic                              scan_valid,
    output logic                              scan_stall,
    input  prsmf_pkg::scan_t                  scan_data,
    output logic                              result_valid,
    input  logic                              result_stall,
    output prsmf_pkg::result_t                result_data
);

    logic                  in_valid_reg;
    prsmf_pkg::scan_t      in_data_reg;
    logic                  out_valid_reg;
    prsmf_pkg::result_t    out_data_reg, out_data_next;
    logic                  advance;
    logic                  accept;
    prsmf_pkg::step_t      step;
    logic [prsmf_pkg::RAW_W-1:0] filt_first;
    logic [prsmf_pkg::RAW_W-1:0] filt_second;

    assign advance    = in_valid_reg && (!out_valid_reg || !result_stall);
    assign scan_stall = in_valid_reg && !advance;
    assign accept     = scan_valid && !scan_stall;

    prsmf_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .advance   (advance),
        .command   (in_data_reg.command),
        .step      (step)
    );

    prsmf_window u_window
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .step            (step),
        .first_raw       (in_data_reg.first_raw),
        .first_bus_ok    (in_data_reg.first_bus_ok),
        .second_raw      (in_data_reg.second_raw),
        .second_bus_ok   (in_data_reg.second_bus_ok),
        .filtered_first  (filt_first),
        .filtered_second (filt_second)
    );

    always_comb
    begin
        out_data_next.action          = step.action;
        out_data_next.pair_index      = step.pair;
        out_data_next.filtered_first  = filt_first;
        out_data_next.filtered_second = filt_second;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (!result_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            in_data_reg <= scan_data;
        if (advance)
            out_data_reg <= out_data_next;
    end

    assign result_valid = out_valid_reg;
    assign result_data  = out_data_reg;

endmodule

FILE: rtl/prsmf_window.sv
// ----------------------------------------------------------------------------
// prsmf_window
// Per-channel three-sample windows with input cleaning and median select.
// ----------------------------------------------------------------------------
module prsmf_window
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  prsmf_pkg::step_t              step,
    input  logic [prsmf_pkg::RAW_W-1:0]   first_raw,
    input  logic                          first_bus_ok,
    input  logic [prsmf_pkg::RAW_W-1:0]   second_raw,
    input  logic                          second_bus_ok,
    output logic [prsmf_pkg::RAW_W-1:0]   filtered_first,
    output logic [prsmf_pkg::RAW_W-1:0]   filtered_second
);

    logic [prsmf_pkg::RAW_W-1:0] win_reg [prsmf_pkg::SENSOR_COUNT][prsmf_pkg::WINDOW_TAPS];
    logic [prsmf_pkg::RAW_W-1:0] sample   [prsmf_pkg::SENSOR_COUNT];
    logic [prsmf_pkg::RAW_W-1:0] med      [prsmf_pkg::SENSOR_COUNT];
    logic [prsmf_pkg::RAW_W-1:0] first_clean;
    logic [prsmf_pkg::RAW_W-1:0] second_clean;

    assign first_clean  = prsmf_pkg::clean_value(first_raw, first_bus_ok);
    assign second_clean = prsmf_pkg::clean_value(second_raw, second_bus_ok);

    // even channel: first sensor of pair, odd: second sensor
    for (genvar ch = 0; ch < prsmf_pkg::SENSOR_COUNT; ch++)
    begin : g_chan
        localparam logic CH_PAIR = 1'((ch / 2) % 2);

        assign sample[ch] = ((ch % 2) == 0) ? first_clean : second_clean;
        assign med[ch]    = prsmf_pkg::median3(sample[ch], win_reg[ch][0], win_reg[ch][1]);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                for (int t = 0; t < prsmf_pkg::WINDOW_TAPS; t++)
                    win_reg[ch][t] <= '0;
            end
            else if (step.enable && (step.action == prsmf_pkg::ACT_FILTERED)
                     && (step.pair == CH_PAIR))
            begin
                win_reg[ch][0] <= sample[ch];
                for (int t = 1; t < prsmf_pkg::WINDOW_TAPS; t++)
                    win_reg[ch][t] <= win_reg[ch][t-1];
            end
        end
    end

    always_comb
    begin
        filtered_first  = '0;
        filtered_second = '0;
        if (step.action == prsmf_pkg::ACT_FILTERED)
        begin
            filtered_first  = step.pair ? med[2] : med[0];
            filtered_second = step.pair ? med[3] : med[1];
        end
    end

endmodule

FILE: rtl/prsmf_ctrl.sv
// ----------------------------------------------------------------------------
// prsmf_ctrl
// Scan sequencer: phase, current pair, wait counter and wait registers.
// ----------------------------------------------------------------------------
module prsmf_ctrl
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [prsmf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [prsmf_pkg::WAIT_W-1:0]      cfg_data,
    input  logic                              advance,
    input  logic                              command,
    output prsmf_pkg::step_t                  step
);

    prsmf_pkg::phase_t               phase_reg, phase_next;
    logic                            pair_reg, pair_next;
    logic [prsmf_pkg::WAIT_W-1:0]    elapsed_reg, elapsed_next;
    logic [prsmf_pkg::WAIT_W-1:0]    wait0_reg, wait1_reg;
    logic [prsmf_pkg::WAIT_W-1:0]    wait_sel;
    logic [prsmf_pkg::WAIT_W-1:0]    elapsed_inc;
    logic [1:0]                      action;

    assign wait_sel    = pair_reg ? wait1_reg : wait0_reg;
    assign elapsed_inc = (elapsed_reg != prsmf_pkg::ELAPSED_MAX)
                         ? elapsed_reg + 1'b1 : elapsed_reg;

    always_comb
    begin
        phase_next   = phase_reg;
        pair_next    = pair_reg;
        elapsed_next = elapsed_reg;
        action       = prsmf_pkg::ACT_NONE;
        if (command == prsmf_pkg::CMD_TICK)
        begin
            case (phase_reg)
                prsmf_pkg::PH_WAIT:
                begin
                    elapsed_next = elapsed_inc;
                    if (elapsed_inc >= wait_sel)
                    begin
                        action     = prsmf_pkg::ACT_READ;
                        phase_next = prsmf_pkg::PH_AWAIT;
                    end
                end
                prsmf_pkg::PH_AWAIT:
                begin
                    action = prsmf_pkg::ACT_NONE;
                end
                default:
                begin
                    action       = prsmf_pkg::ACT_TRIGGER;
                    elapsed_next = '0;
                    phase_next   = prsmf_pkg::PH_WAIT;
                end
            endcase
        end
        else if (phase_reg == prsmf_pkg::PH_AWAIT)
        begin
            action     = prsmf_pkg::ACT_FILTERED;
            pair_next  = !pair_reg;
            phase_next = prsmf_pkg::PH_TRIGGER;
        end
    end

    assign step.enable = advance;
    assign step.pair   = pair_reg;
    assign step.action = action;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= prsmf_pkg::PH_TRIGGER;
            pair_reg    <= 1'b0;
            elapsed_reg <= '0;
        end
        else if (advance)
        begin
            phase_reg   <= phase_next;
            pair_reg    <= pair_next;
            elapsed_reg <= elapsed_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wait0_reg <= prsmf_pkg::WAIT_RESET;
            wait1_reg <= prsmf_pkg::WAIT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                prsmf_pkg::REG_WAIT_PAIR0: wait0_reg <= cfg_data;
                prsmf_pkg::REG_WAIT_PAIR1: wait1_reg <= cfg_data;
                default: ;
            endcase
        end
    end

endmodule
